// ----- sv/atcp_pkg.sv -----
// ============================================================================
// atcp_pkg
// Shared types and constants of the terminal character processor.
// ============================================================================
`default_nettype none

package atcp_pkg;

    localparam int MAX_PARAMS_DEF = 8;
    localparam int PARAM_BITS_DEF = 16;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0] INTENSITY_BIT = 4'(1 << 3);
    localparam logic [3:0] FG_RESET      = 4'd15;
    localparam logic [3:0] BG_RESET      = 4'd0;
    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;

    localparam int FG_LO = 30;
    localparam int FG_HI = 37;
    localparam int BG_LO = 40;
    localparam int BG_HI = 47;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI
    } atcp_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK_ADDR,
        ST_WALK_USE,
        ST_POS_ADDR,
        ST_POS_USE,
        ST_EMIT
    } atcp_state_t;

    typedef struct packed {
        logic       is_one;
        logic       fg_hit;
        logic       bg_hit;
        logic [2:0] fg_code;
        logic [2:0] bg_code;
        logic       pos_ok;
        logic [7:0] pos;
    } atcp_alu_res_t;

endpackage

`default_nettype wire

// ----- sv/atcp_param_mem.sv -----
// ============================================================================
// atcp_param_mem
// Storage for the parameters of one escape sequence, registered read.
// ============================================================================
`default_nettype none

module atcp_param_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/atcp_alu.sv -----
// ============================================================================
// atcp_alu
// Shared compare unit that classifies one stored parameter.
// ============================================================================
`default_nettype none

module atcp_alu #(
    parameter int PARAM_BITS = 16
) (
    input  wire logic [PARAM_BITS-1:0]       value,
    input  wire logic [7:0]                  limit,
    output atcp_pkg::atcp_alu_res_t          res
);

    import atcp_pkg::*;

    logic [PARAM_BITS-1:0] pos_full;

    always_comb
    begin
        pos_full = (value == '0) ? '0 : value - PARAM_BITS'(1);
        res.is_one  = (value == PARAM_BITS'(1));
        res.fg_hit  = (value >= PARAM_BITS'(FG_LO)) && (value <= PARAM_BITS'(FG_HI));
        res.bg_hit  = (value >= PARAM_BITS'(BG_LO)) && (value <= PARAM_BITS'(BG_HI));
        res.fg_code = value[2:0] + 3'd2;
        res.bg_code = value[2:0];
        res.pos_ok  = (pos_full < PARAM_BITS'(limit));
        res.pos     = pos_full[7:0];
    end

endmodule

`default_nettype wire

// ----- sv/ansi_terminal_char_processor_core.sv -----
// ============================================================================
// ansi_terminal_char_processor_core
// Terminal byte processor with cursor, colors and a CSI escape parser.
// ============================================================================
// One byte is requested on in_byte with in_valid; the block holds in_stall
// high while it works on a byte. Every byte gives exactly one result on the
// output channel, held until out_stall is low at a clock edge.
// A plain byte or a newline goes from the byte register through the execute
// state to the emit state, which loads the result register and frees the
// block. The final byte of a CSI sequence passes more states: 'm' walks each
// stored parameter through the shared compare unit in an address state and
// a use state, as do 'H' with two and 'G' with one parameter, since each
// parameter is read from the registered parameter memory before it is checked.
// The next byte is accepted as soon as a result is loaded, even while that
// result still waits for the receiver; the following result waits inside
// the block until the output register is free.
// Reset returns the parser to text mode, the cursor to the top left corner,
// the colors to white on black and the screen size to 80 by 25.
// Configuration writes on cfg_wen are taken at any edge.
// ============================================================================
`default_nettype none

module ansi_terminal_char_processor_core #(
    parameter int MAX_PARAMS = atcp_pkg::MAX_PARAMS_DEF,
    parameter int PARAM_BITS = atcp_pkg::PARAM_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wen,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            cell_valid,
    output logic      [7:0] cell_col,
    output logic      [7:0] cell_row,
    output logic      [7:0] cell_char,
    output logic      [3:0] cell_fg,
    output logic      [3:0] cell_bg,
    output logic            scroll_up,
    output logic      [7:0] cur_col,
    output logic      [7:0] cur_row
);

    import atcp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PARAMS);
    localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
    localparam int EXT_W  = PARAM_BITS + 4;

    atcp_state_t           state_reg, state_next;
    atcp_mode_t            mode_reg, mode_next;
    logic [PARAM_BITS-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  over_reg, over_next;
    logic [7:0]            col_reg, col_next;
    logic [7:0]            row_reg, row_next;
    logic [3:0]            fg_reg, fg_next;
    logic [3:0]            bg_reg, bg_next;
    logic [7:0]            columns_reg;
    logic [7:0]            rows_reg;
    logic                  out_valid_reg, out_valid_next;

    logic [7:0]            byte_reg, byte_next;
    logic                  final_h_reg, final_h_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pass_reg, pass_next;
    logic [7:0]            tmp_col_reg, tmp_col_next;
    logic                  tmp_ok_reg, tmp_ok_next;
    logic [3:0]            inten_reg, inten_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  res_scroll_reg, res_scroll_next;
    logic [7:0]            res_col_reg, res_col_next;
    logic [7:0]            res_row_reg, res_row_next;
    logic [7:0]            res_char_reg, res_char_next;
    logic [3:0]            res_fg_reg, res_fg_next;
    logic [3:0]            res_bg_reg, res_bg_next;
    logic                  load_out;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [PARAM_BITS-1:0] mem_rdata;
    logic [7:0]            alu_limit;
    atcp_alu_res_t         alu_res;

    logic [7:0]            eff_cols;
    logic [7:0]            eff_rows;
    logic [8:0]            col_inc;
    logic [EXT_W-1:0]      acc_mul;
    logic                  push_room;
    logic [CNT_W-1:0]      count_post;
    logic                  over_post;

    atcp_param_mem #(
        .DEPTH (MAX_PARAMS),
        .WIDTH (PARAM_BITS)
    ) u_param_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (acc_reg),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    atcp_alu #(
        .PARAM_BITS (PARAM_BITS)
    ) u_alu (
        .value (mem_rdata),
        .limit (alu_limit),
        .res   (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_NORMAL;
            acc_reg       <= '0;
            count_reg     <= '0;
            over_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            columns_reg   <= COLUMNS_RESET;
            rows_reg      <= ROWS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            over_reg      <= over_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_COLUMNS: columns_reg <= cfg_wdata;
                    CFG_ROWS:    rows_reg    <= cfg_wdata;
                    default:     columns_reg <= columns_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        final_h_reg    <= final_h_next;
        idx_reg        <= idx_next;
        pass_reg       <= pass_next;
        tmp_col_reg    <= tmp_col_next;
        tmp_ok_reg     <= tmp_ok_next;
        inten_reg      <= inten_next;
        res_valid_reg  <= res_valid_next;
        res_scroll_reg <= res_scroll_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        res_char_reg   <= res_char_next;
        res_fg_reg     <= res_fg_next;
        res_bg_reg     <= res_bg_next;
        if (load_out)
        begin
            cell_valid <= res_valid_reg;
            cell_col   <= res_col_reg;
            cell_row   <= res_row_reg;
            cell_char  <= res_char_reg;
            cell_fg    <= res_fg_reg;
            cell_bg    <= res_bg_reg;
            scroll_up  <= res_scroll_reg;
            cur_col    <= col_reg;
            cur_row    <= row_reg;
        end
    end

    always_comb
    begin
        eff_cols   = (columns_reg == 8'd0) ? 8'd1 : columns_reg;
        eff_rows   = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
        col_inc    = {1'b0, col_reg} + 9'd1;
        acc_mul    = (EXT_W'(acc_reg) << 3) + (EXT_W'(acc_reg) << 1)
                     + EXT_W'(byte_reg[3:0]);
        push_room  = (count_reg < CNT_W'(MAX_PARAMS));
        count_post = push_room ? count_reg + CNT_W'(1) : count_reg;
        over_post  = over_reg || !push_room;
        alu_limit  = (pass_reg) ? eff_rows : eff_cols;

        state_next      = state_reg;
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        over_next       = over_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        out_valid_next  = out_valid_reg;
        byte_next       = byte_reg;
        final_h_next    = final_h_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        tmp_col_next    = tmp_col_reg;
        tmp_ok_next     = tmp_ok_reg;
        inten_next      = inten_reg;
        res_valid_next  = res_valid_reg;
        res_scroll_next = res_scroll_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        res_char_next   = res_char_reg;
        res_fg_next     = res_fg_reg;
        res_bg_next     = res_bg_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        load_out        = 1'b0;
        in_stall        = (state_reg != ST_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = in_byte;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_valid_next  = 1'b0;
                res_scroll_next = 1'b0;
                res_col_next    = '0;
                res_row_next    = '0;
                res_char_next   = '0;
                res_fg_next     = '0;
                res_bg_next     = '0;
                state_next      = ST_EMIT;
                case (mode_reg)
                    MODE_ESC:
                    begin
                        mode_next = MODE_NORMAL;
                        if (byte_reg == CH_LBRACK)
                        begin
                            mode_next  = MODE_CSI;
                            acc_next   = '0;
                            count_next = '0;
                            over_next  = 1'b0;
                        end
                    end
                    MODE_CSI:
                    begin
                        if (byte_reg >= CH_ZERO && byte_reg <= CH_NINE)
                        begin
                            if (acc_mul[EXT_W-1:PARAM_BITS] != '0)
                            begin
                                acc_next = '1;
                            end
                            else
                            begin
                                acc_next = acc_mul[PARAM_BITS-1:0];
                            end
                        end
                        else
                        begin
                            mem_we     = push_room;
                            count_next = count_post;
                            over_next  = over_post;
                            acc_next   = '0;
                            if (byte_reg != CH_SEMI)
                            begin
                                mode_next    = MODE_NORMAL;
                                final_h_next = (byte_reg == CH_H);
                                pass_next    = 1'b0;
                                inten_next   = '0;
                                idx_next     = '0;
                                if (byte_reg == CH_M)
                                begin
                                    state_next = ST_WALK_ADDR;
                                end
                                else if (byte_reg == CH_H && !over_post
                                         && count_post == CNT_W'(2))
                                begin
                                    idx_next   = CNT_W'(1);
                                    state_next = ST_POS_ADDR;
                                end
                                else if (byte_reg == CH_G && !over_post
                                         && count_post == CNT_W'(1))
                                begin
                                    state_next = ST_POS_ADDR;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_NORMAL;
                        if (byte_reg == CH_NL)
                        begin
                            col_next = '0;
                            if (row_reg >= eff_rows - 8'd1)
                            begin
                                res_scroll_next = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + 8'd1;
                            end
                        end
                        else if (byte_reg == CH_ESC)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else
                        begin
                            res_valid_next = 1'b1;
                            res_col_next   = col_reg;
                            res_row_next   = row_reg;
                            res_char_next  = byte_reg;
                            res_fg_next    = fg_reg;
                            res_bg_next    = bg_reg;
                            col_next       = col_inc[7:0];
                            if (col_inc >= {1'b0, eff_cols})
                            begin
                                col_next = '0;
                                if (row_reg >= eff_rows - 8'd1)
                                begin
                                    res_scroll_next = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + 8'd1;
                                end
                            end
                        end
                    end
                endcase
            end
            ST_WALK_ADDR:
            begin
                state_next = ST_WALK_USE;
            end
            ST_WALK_USE:
            begin
                if (alu_res.is_one)
                begin
                    inten_next = INTENSITY_BIT;
                end
                if (alu_res.fg_hit)
                begin
                    fg_next = {1'b0, alu_res.fg_code} | (alu_res.is_one ? INTENSITY_BIT
                                                                          : inten_reg);
                end
                if (alu_res.bg_hit)
                begin
                    bg_next = {1'b0, alu_res.bg_code} | inten_reg;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) < count_reg)
                begin
                    state_next = ST_WALK_ADDR;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_POS_ADDR:
            begin
                state_next = ST_POS_USE;
            end
            ST_POS_USE:
            begin
                state_next = ST_EMIT;
                if (!pass_reg)
                begin
                    if (final_h_reg)
                    begin
                        tmp_col_next = alu_res.pos;
                        tmp_ok_next  = alu_res.pos_ok;
                        pass_next    = 1'b1;
                        idx_next     = '0;
                        state_next   = ST_POS_ADDR;
                    end
                    else if (alu_res.pos_ok)
                    begin
                        col_next = alu_res.pos;
                    end
                end
                else if (tmp_ok_reg && alu_res.pos_ok)
                begin
                    col_next = tmp_col_reg;
                    row_next = alu_res.pos;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid = out_valid_reg;
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_ansi_terminal_char_processor_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_ansi_terminal_char_processor_core
// Self-checking testbench for the terminal byte processor.
// Bytes are requested one at a time and a cycle-free model of the parser,
// cursor and colors predicts the result of each accepted request. A checker
// compares every result field by field against the oldest prediction.
// Directed bytes, newlines and escape sequences come first. Random sequences,
// malformed ones among them, follow over several screen sizes, with random
// gaps and stalls on both channels and one long receiver hold-off.
// ============================================================================
module tb_ansi_terminal_char_processor_core;
    import atcp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 48;
    localparam int ACC_MAX      = (1 << PARAM_BITS_DEF) - 1;

    localparam int PK_COLOR = 0;
    localparam int PK_POS   = 1;
    localparam int PK_ANY   = 2;

    typedef struct {
        logic       cell_valid;
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic [7:0] cell_char;
        logic [3:0] cell_fg;
        logic [3:0] cell_bg;
        logic       scroll_up;
        logic [7:0] cur_col;
        logic [7:0] cur_row;
    } cell_report_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wen = 1'b0;
    logic       cfg_index = CFG_COLUMNS;
    logic [7:0] cfg_wdata = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       cell_valid;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [7:0] cell_char;
    logic [3:0] cell_fg;
    logic [3:0] cell_bg;
    logic       scroll_up;
    logic [7:0] cur_col;
    logic [7:0] cur_row;

    atcp_mode_t term_mode = MODE_NORMAL;
    int         seq_acc = 0;
    logic [15:0] seq_params [MAX_PARAMS_DEF];
    int         seq_count = 0;
    bit         seq_over = 1'b0;
    logic [7:0] cursor_x = 8'd0;
    logic [7:0] cursor_y = 8'd0;
    logic [3:0] fg_now = FG_RESET;
    logic [3:0] bg_now = BG_RESET;
    logic [7:0] screen_cols = COLUMNS_RESET;
    logic [7:0] screen_rows = ROWS_RESET;

    cell_report_t pending_reports [$];

    int  cycle_count = 0;
    int  mismatches = 0;
    int  bytes_sent = 0;
    int  results_checked = 0;
    int  cells_written = 0;
    int  scrolls_seen = 0;
    int  sizes_used = 1;
    int  hold_cycles = 0;
    bit  sender_idle_on = 1'b1;
    bit  receiver_idle_on = 1'b1;

    ansi_terminal_char_processor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_valid(cell_valid),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .cell_char (cell_char),
        .cell_fg   (cell_fg),
        .cell_bg   (cell_bg),
        .scroll_up (scroll_up),
        .cur_col   (cur_col),
        .cur_row   (cur_row)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int eff_size(logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    function automatic int to_position(logic [15:0] v);
        return ((v == 16'd0) ? 1 : int'(v)) - 1;
    endfunction

    function automatic bit next_line();
        cursor_x = 8'd0;
        if (int'(cursor_y) >= eff_size(screen_rows) - 1)
            return 1'b1;
        cursor_y = cursor_y + 8'd1;
        return 1'b0;
    endfunction

    function automatic void push_seq_param();
        if (seq_count < MAX_PARAMS_DEF)
        begin
            seq_params[seq_count] = seq_acc[15:0];
            seq_count++;
        end
        else
            seq_over = 1'b1;
        seq_acc = 0;
    endfunction

    function automatic void run_final_byte(logic [7:0] fin);
        int inten;
        int v;
        int px;
        int py;
        if (fin == CH_M)
        begin
            inten = 0;
            for (int i = 0; i < seq_count; i++)
            begin
                v = int'(seq_params[i]);
                if (v == 1)
                    inten = int'(INTENSITY_BIT);
                if (v >= FG_LO && v <= FG_HI)
                    fg_now = 4'((v - FG_LO) | inten);
                if (v >= BG_LO && v <= BG_HI)
                    bg_now = 4'((v - BG_LO) | inten);
            end
        end
        else if (fin == CH_H)
        begin
            if (!seq_over && seq_count == 2)
            begin
                py = to_position(seq_params[0]);
                px = to_position(seq_params[1]);
                if (px < eff_size(screen_cols) && py < eff_size(screen_rows))
                begin
                    cursor_x = 8'(px);
                    cursor_y = 8'(py);
                end
            end
        end
        else if (fin == CH_G)
        begin
            if (!seq_over && seq_count == 1)
            begin
                px = to_position(seq_params[0]);
                if (px < eff_size(screen_cols))
                    cursor_x = 8'(px);
            end
        end
    endfunction

    function automatic cell_report_t apply_terminal_byte(logic [7:0] b);
        cell_report_t r;
        int t;
        int nx;
        r = '{default: '0};
        case (term_mode)
            MODE_ESC:
            begin
                if (b == CH_LBRACK)
                begin
                    term_mode = MODE_CSI;
                    seq_acc = 0;
                    seq_count = 0;
                    seq_over = 1'b0;
                end
                else
                    term_mode = MODE_NORMAL;
            end
            MODE_CSI:
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    t = seq_acc * 10 + int'(b) - int'(CH_ZERO);
                    seq_acc = (t > ACC_MAX) ? ACC_MAX : t;
                end
                else if (b == CH_SEMI)
                    push_seq_param();
                else
                begin
                    push_seq_param();
                    run_final_byte(b);
                    term_mode = MODE_NORMAL;
                end
            end
            default:
            begin
                if (b == CH_NL)
                    r.scroll_up = next_line();
                else if (b == CH_ESC)
                    term_mode = MODE_ESC;
                else
                begin
                    r.cell_valid = 1'b1;
                    r.cell_col = cursor_x;
                    r.cell_row = cursor_y;
                    r.cell_char = b;
                    r.cell_fg = fg_now;
                    r.cell_bg = bg_now;
                    nx = int'(cursor_x) + 1;
                    if (nx >= eff_size(screen_cols))
                        r.scroll_up = next_line();
                    else
                        cursor_x = 8'(nx);
                end
            end
        endcase
        r.cur_col = cursor_x;
        r.cur_row = cursor_y;
        return r;
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        cell_report_t predicted;
        if (sender_idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = apply_terminal_byte(b);
        pending_reports = {pending_reports, predicted};
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(8'(s[i]));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == CFG_COLUMNS)
            screen_cols = val;
        else
            screen_rows = val;
        @(posedge clk);
    endtask

    task automatic set_screen(logic [7:0] cols, logic [7:0] rows);
        wait_idle();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        sizes_used++;
    endtask

    function automatic longint pick_param(int kind, int lim);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return -1;
        case (kind)
            PK_COLOR:
            begin
                if (r <= 2)
                    return 1;
                if (r <= 5)
                    return FG_LO + $urandom_range(0, 7);
                if (r <= 8)
                    return BG_LO + $urandom_range(0, 7);
                return $urandom_range(0, 120);
            end
            PK_POS:
            begin
                if (r == 1)
                    return 0;
                if (r == 2)
                    return $urandom_range(256, 99999999);
                if (r == 3)
                    return $urandom_range(1, 257);
                return $urandom_range(1, lim + 1);
            end
            default:
            begin
                if (r == 1)
                    return $urandom_range(0, 9);
                if (r == 2)
                    return longint'($urandom());
                return $urandom_range(0, 999);
            end
        endcase
    endfunction

    task automatic send_csi(logic [7:0] fin, int count, int kind);
        longint v;
        int lim;
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        for (int i = 0; i < count; i++)
        begin
            if (i > 0)
                send_byte(CH_SEMI);
            lim = (fin == CH_H && i == 0) ? eff_size(screen_rows) : eff_size(screen_cols);
            v = pick_param(kind, lim);
            if (v >= 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(CH_ZERO);
                send_text($sformatf("%0d", v));
            end
        end
        send_byte(fin);
    endtask

    function automatic int pick_count(int usual);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(MAX_PARAMS_DEF - 1, MAX_PARAMS_DEF + 3);
        if (r == 1)
            return $urandom_range(0, 4);
        return usual;
    endfunction

    task automatic send_random_sequence();
        int pick;
        int n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_ESC)
                    b = 8'h41;
                send_byte(b);
            end
        end
        else if (pick < 40)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(CH_NL);
        end
        else if (pick < 55)
            send_csi(CH_M, pick_count($urandom_range(0, 4)), PK_COLOR);
        else if (pick < 70)
            send_csi(CH_H, pick_count(2), PK_POS);
        else if (pick < 80)
            send_csi(CH_G, pick_count(1), PK_POS);
        else if (pick < 86)
        begin
            send_byte(CH_ESC);
            b = 8'($urandom_range(0, 255));
            if (b == CH_LBRACK)
                b = CH_ESC;
            send_byte(b);
        end
        else if (pick < 93)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI);
            send_csi(b, $urandom_range(0, 4), PK_ANY);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        cell_report_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with no request pending: cell_valid %0d, cur_col %0d",
                       cell_valid, cur_col);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("cell_valid", 8'(want.cell_valid), 8'(cell_valid));
                check_field("cell_col", want.cell_col, cell_col);
                check_field("cell_row", want.cell_row, cell_row);
                check_field("cell_char", want.cell_char, cell_char);
                check_field("cell_fg", 8'(want.cell_fg), 8'(cell_fg));
                check_field("cell_bg", 8'(want.cell_bg), 8'(cell_bg));
                check_field("scroll_up", 8'(want.scroll_up), 8'(scroll_up));
                check_field("cur_col", want.cur_col, cur_col);
                check_field("cur_row", want.cur_row, cur_row);
                results_checked++;
                if (want.cell_valid)
                    cells_written++;
                if (want.scroll_up)
                    scrolls_seen++;
            end
        end
    end

    always
    begin : receiver_pace
        int n;
        int len;
        @(posedge clk);
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            n = 0;
            while (n < hold_cycles)
            begin
                @(posedge clk);
                n++;
            end
            out_stall <= 1'b0;
            hold_cycles = 0;
        end
        else if (receiver_idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            len = $urandom_range(1, 17);
            repeat (len) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ansi_terminal_char_processor_core");
            $finish;
        end
    end

    task automatic test_plain_and_newline();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_NL);
    endtask

    task automatic test_escape_drop();
        send_byte(CH_ESC);
        send_byte(8'h78);
    endtask

    task automatic test_color_codes();
        send_byte(CH_ESC);
        send_text("[1;31;42m");
        send_byte(8'h41);
    endtask

    task automatic test_cursor_moves();
        send_byte(CH_ESC);
        send_text("[3;5H");
        send_byte(CH_ESC);
        send_text("[G");
        send_byte(8'h42);
    endtask

    task automatic test_param_overflow();
        send_byte(CH_ESC);
        send_text("[;;;;;;;;1H");
    endtask

    task automatic test_size_edges();
        // The cursor is left outside a screen that shrinks to its minimum,
        // and a sequence is split across a register write.
        set_screen(8'd0, 8'd0);
        send_byte(8'h5A);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        wait_idle();
        write_reg(CFG_ROWS, 8'd1);
        send_text("1;1H");
        send_byte(8'h41);
    endtask

    task automatic test_backpressure();
        int start;
        wait_idle();
        hold_cycles = 400;
        start = bytes_sent;
        while (bytes_sent - start < 30)
            send_random_sequence();
        wait_idle();
    endtask

    task automatic test_random_traffic(logic [7:0] cols, logic [7:0] rows, int count);
        int start;
        set_screen(cols, rows);
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_random_sequence();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_and_newline();
        test_escape_drop();
        test_color_codes();
        test_cursor_moves();
        test_param_overflow();
        test_size_edges();

        test_random_traffic(COLUMNS_RESET, ROWS_RESET, 130);
        test_backpressure();
        test_random_traffic(8'd1, 8'd1, 130);
        test_random_traffic(8'd255, 8'd255, 130);
        test_random_traffic(8'd3, 8'd2, 130);
        test_random_traffic(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 130);

        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        test_random_traffic(COLUMNS_RESET, ROWS_RESET, 150);

        wait_idle();
        $display("Run covered %0d requests over %0d screen sizes with gaps, stalls and a long hold.",
                 bytes_sent, sizes_used);
        $display("Checked %0d results: %0d cell writes, %0d scrolls, %0d mismatches.",
                 results_checked, cells_written, scrolls_seen, mismatches);
        if (mismatches == 0)
            $display("PASS ansi_terminal_char_processor_core");
        else
            $display("FAIL ansi_terminal_char_processor_core");
        $finish;
    end

endmodule

// ----- ansi_terminal_char_processor_core.f -----
sv/atcp_pkg.sv
sv/atcp_param_mem.sv
sv/atcp_alu.sv
sv/ansi_terminal_char_processor_core.sv
tb/sv/tb_ansi_terminal_char_processor_core.sv
